[design/ksm_pkg.sv]
`default_nettype none

package ksm_pkg;

  localparam int KEY_W               = 8;
  localparam int LEN_W               = 4;
  localparam int CFG_W               = 60;
  localparam int SLOT_W              = 2;
  localparam int KEYS_PER_SLOT       = 7;
  localparam int CFG_IDX_W           = 4;
  localparam int MAX_PATTERN_LEN_DEF = 7;
  localparam int NUM_PATTERNS_DEF    = 4;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CFG_W-1:0]  pat_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic  hit;
    slot_t slot;
  } match_t;

endpackage

`default_nettype wire

[design/ksm_if.sv]
`default_nettype none

interface ksm_key_if import ksm_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_code;

  modport src  (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface ksm_res_if import ksm_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  matched;
  slot_t match_slot;

  modport src  (output valid, output matched, output match_slot, input ready);
  modport sink (input valid, input matched, input match_slot, output ready);
endinterface

interface ksm_cfg_if import ksm_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  pat_t     data;

  modport src  (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/ksm_match.sv]
`default_nettype none

module ksm_match
  import ksm_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  wire logic [MAX_PATTERN_LEN-1:0][KEY_W-1:0] hist_i,
  input  wire logic [FILL_W-1:0]                     fill_i,
  input  wire logic [NUM_PATTERNS-1:0][CFG_W-1:0]    pat_i,
  output match_t                                     res_o
);

  localparam int LMAX = (MAX_PATTERN_LEN < KEYS_PER_SLOT) ? MAX_PATTERN_LEN : KEYS_PER_SLOT;

  logic [NUM_PATTERNS-1:0] hit;

  // per slot: pick the comparison of the configured length
  always_comb begin
    logic m;
    hit = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      for (int l = 1; l <= LMAX; l++) begin
        m = 1'b1;
        for (int j = 0; j < l; j++) begin
          if (pat_i[p][KEY_W*(l-1-j)+LEN_W +: KEY_W] != hist_i[j]) begin
            m = 1'b0;
          end
        end
        if (pat_i[p][LEN_W-1:0] == LEN_W'(l) && fill_i >= FILL_W'(l) && m) begin
          hit[p] = 1'b1;
        end
      end
    end
  end

  // lowest slot wins
  always_comb begin
    res_o = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (hit[p]) begin
        res_o.hit  = 1'b1;
        res_o.slot = SLOT_W'(p);
      end
    end
  end

endmodule

`default_nettype wire

[design/key_sequence_suffix_matcher_top.sv]
// Key sequence suffix matcher.
// in_key  : one key code per beat (valid/ready).
// out_res : one result per key: matched and the lowest matching slot
//           (slot 0 when nothing matched).
// cfg_bus : pattern writes, index 0..NUM_PATTERNS-1; other indexes are
//           dropped. Always ready. Write only while the block is idle.
// Pattern packing: bits 3:0 length (0 = off, over 7 or over
// MAX_PATTERN_LEN = never), key i at bits 8i+11:8i+4, oldest first.
// Path: a key beat is registered in the history register, and its
// result then in the result register.
// Throughput: one key per cycle while out_res is not held; the
// comparators check every slot and every length in parallel, combinationally.
// Reset: patterns cleared (all slots off), history and key count
// cleared, both pipeline stages empty.
// Stall: while out_res is held, the result and history stages hold;
// in_key stays ready until both stages are full.
`default_nettype none

module key_sequence_suffix_matcher_top
  import ksm_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ksm_key_if.sink   in_key,
  ksm_res_if.src    out_res,
  ksm_cfg_if.sink   cfg_bus
);

  localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);

  logic [NUM_PATTERNS-1:0][CFG_W-1:0]    pat_r;
  logic [MAX_PATTERN_LEN-1:0][KEY_W-1:0] hist_r, hist_nxt;
  logic [FILL_W-1:0]                     fill_r, fill_nxt;
  logic                                  s1_vld_r;
  logic                                  out_vld_r;
  logic                                  out_matched_r;
  slot_t                                 out_slot_r;
  logic                                  in_acc, out_adv, s1_adv;
  match_t                                mres;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
    end else if (cfg_bus.valid) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        if (cfg_bus.index == CFG_IDX_W'(i)) begin
          pat_r[i] <= cfg_bus.data;
        end
      end
    end
  end

  assign out_adv      = !out_vld_r || out_res.ready;
  assign s1_adv       = s1_vld_r && out_adv;
  assign in_key.ready = !s1_vld_r || out_adv;
  assign in_acc       = in_key.valid && in_key.ready;

  always_comb begin
    hist_nxt[0] = in_key.key_code;
    for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
    fill_nxt = (fill_r == FILL_W'(MAX_PATTERN_LEN)) ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      fill_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        hist_r <= hist_nxt;
        fill_r <= fill_nxt;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  ksm_match #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .NUM_PATTERNS    (NUM_PATTERNS)
  ) u_match (
    .hist_i (hist_r),
    .fill_i (fill_r),
    .pat_i  (pat_r),
    .res_o  (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_matched_r <= mres.hit;
      out_slot_r    <= mres.slot;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.matched    = out_matched_r;
  assign out_res.match_slot = out_slot_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_PATTERN_LEN))
    else $error("key count above history depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fill_r != FILL_W'(MAX_PATTERN_LEN) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("key count did not advance");

  a_hist_newest: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> hist_r[0] == $past(in_key.key_code))
    else $error("history lost newest key");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_adv |=> s1_vld_r && $stable(hist_r))
    else $error("history stage moved under stall");

  a_nomatch_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_matched_r |-> out_slot_r == '0)
    else $error("slot set without match");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ksm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_PHASES  = 12;
  localparam int KEYS_PER_PHASE = 130;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_ZERO  = 0,
    REG_PATTERN_ONE   = 1,
    REG_PATTERN_TWO   = 2,
    REG_PATTERN_THREE = 3
  } pat_reg_e;

  typedef enum int {PH_RANDOM, PH_ALL_ONES, PH_SOLID} phase_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  ksm_key_if key_ch ();
  ksm_res_if res_ch ();
  ksm_cfg_if cfg_ch ();

  key_sequence_suffix_matcher_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_key  (key_ch),
    .out_res (res_ch),
    .cfg_bus (cfg_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  pat_t   pattern_q [NUM_PATTERNS_DEF];
  key_t   history_q [MAX_PATTERN_LEN_DEF];
  int     keys_seen;
  match_t expected_q[$];
  key_t   pending_keys[$];

  int  keys_pushed;
  int  keys_accepted;
  int  errors;
  int  hold_requests;
  int  hold_served;
  int  key_gap_left;
  int  res_stall_left;
  int  idle_cycles;
  bit  key_gaps_on;
  bit  res_stall_on;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // shift in one key and find the lowest slot whose pattern ends the history
  function automatic match_t shift_and_match(key_t k);
    match_t res;
    int     len;
    bit     hit;
    res = '0;
    for (int i = MAX_PATTERN_LEN_DEF - 1; i > 0; i--) history_q[i] = history_q[i-1];
    history_q[0] = k;
    if (keys_seen < MAX_PATTERN_LEN_DEF) keys_seen++;
    for (int s = 0; s < NUM_PATTERNS_DEF; s++) begin
      len = int'(pattern_q[s][LEN_W-1:0]);
      if (len == 0 || len > KEYS_PER_SLOT || len > MAX_PATTERN_LEN_DEF || len > keys_seen)
        continue;
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (pattern_q[s][8*(len-1-j)+LEN_W +: KEY_W] != history_q[j]) hit = 1'b0;
      end
      if (hit) begin
        res.hit  = 1'b1;
        res.slot = slot_t'(s);
        break;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // key driver
  always @(posedge clk) begin : key_driver
    logic offer;
    if (!rst_n) begin
      key_ch.valid    <= 1'b0;
      key_ch.key_code <= '0;
      key_gap_left = 0;
    end else begin
      offer = key_ch.valid;
      if (key_ch.valid && key_ch.ready) begin
        expected_q.push_back(shift_and_match(key_ch.key_code));
        keys_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (key_gap_left > 0) begin
          key_gap_left--;
        end else if (pending_keys.size() > 0) begin
          key_ch.key_code <= pending_keys.pop_front();
          offer = 1'b1;
          key_gap_left = key_gaps_on ? pick_gap() : 0;
        end
      end
      key_ch.valid <= offer;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    match_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      res_stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", int'(res_ch.matched), -1);
        end else begin
          want = expected_q.pop_front();
          if (res_ch.matched !== want.hit)
            report_mismatch("matched", int'(res_ch.matched), int'(want.hit));
          if (res_ch.match_slot !== want.slot)
            report_mismatch("match_slot", int'(res_ch.match_slot), int'(want.slot));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        res_stall_left = LONG_HOLD;
      end else if (res_stall_left == 0 && res_stall_on && $urandom_range(0, 3) == 0) begin
        res_stall_left = pick_gap();
      end
      if (res_stall_left > 0) begin
        res_stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_pattern(input cfg_idx_t idx, input pat_t data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < NUM_PATTERNS_DEF) pattern_q[idx] = data;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_key(input key_t k);
    pending_keys.push_back(k);
    keys_pushed++;
  endtask

  task automatic drain();
    while (keys_accepted != keys_pushed) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input phase_kind_e kind);
    key_t alphabet[3];
    bit   narrow;
    pat_t pat;
    int   len;
    int   s;
    int   r;
    int   target;
    narrow = $urandom_range(0, 1);
    for (int i = 0; i < 3; i++) alphabet[i] = key_t'($urandom);
    for (int slot = 0; slot < NUM_PATTERNS_DEF; slot++) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 7);
      else if (r == 7) len = 0;
      else if (r == 8) len = $urandom_range(8, 15);
      else len = $urandom_range(1, 3);
      pat = pat_t'({$urandom, $urandom});
      if (narrow) begin
        for (int i = 0; i < KEYS_PER_SLOT; i++)
          pat[8*i+LEN_W +: KEY_W] = alphabet[$urandom_range(0, 2)];
      end
      pat[LEN_W-1:0] = len[LEN_W-1:0];
      if (kind == PH_ALL_ONES) pat = '1;
      if (kind == PH_SOLID) pat = {{KEYS_PER_SLOT{8'hFF}}, 4'd7};
      write_pattern(cfg_idx_t'(slot), pat);
    end
    if ($urandom_range(0, 2) == 0)
      write_pattern(cfg_idx_t'($urandom_range(NUM_PATTERNS_DEF, 15)), pat_t'({$urandom, $urandom}));
    target = keys_pushed + KEYS_PER_PHASE;
    while (keys_pushed < target) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NUM_PATTERNS_DEF - 1);
      len = int'(pattern_q[s][LEN_W-1:0]);
      if (r < 75 && len >= 1 && len <= KEYS_PER_SLOT) begin
        if (r < 15) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) push_key(pattern_q[s][8*i+LEN_W +: KEY_W]);
      end else if (narrow || kind == PH_SOLID) begin
        push_key($urandom_range(0, 3) == 0 ? key_t'($urandom) :
                 (kind == PH_SOLID ? 8'hFF : alphabet[$urandom_range(0, 2)]));
      end else begin
        push_key(key_t'($urandom));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    key_ch.valid    = 1'b0;
    key_ch.key_code = '0;
    res_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    for (int i = 0; i < NUM_PATTERNS_DEF; i++) pattern_q[i] = '0;
    for (int i = 0; i < MAX_PATTERN_LEN_DEF; i++) history_q[i] = '0;
    keys_seen     = 0;
    keys_pushed   = 0;
    keys_accepted = 0;
    errors        = 0;
    hold_requests = 0;
    hold_served   = 0;
    key_gaps_on   = 1'b0;
    res_stall_on  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero pattern needs three keys even though history resets to zero;
    // disabled and overlong slots must never hit
    write_pattern(REG_PATTERN_ZERO,  {{4{8'h00}}, {3{8'h00}}, 4'd3});
    write_pattern(REG_PATTERN_ONE,   {{KEYS_PER_SLOT{8'hFF}}, 4'd0});
    write_pattern(REG_PATTERN_TWO,   {{KEYS_PER_SLOT{8'h00}}, 4'd8});
    write_pattern(REG_PATTERN_THREE, {{6{8'h00}}, 8'hFF, 4'd1});
    push_key(8'h00);
    push_key(8'h00);
    push_key(8'h00);
    push_key(8'hFF);
    push_key(8'h00);
    drain();

    // overlapping suffixes: lowest slot wins; out-of-range writes dropped
    write_pattern(REG_PATTERN_ZERO,
                  {8'h7F, 8'h80, 8'h01, 8'h5A, 8'hA5, 8'h00, 8'hFF, 4'd7});
    write_pattern(REG_PATTERN_ONE, '1);
    write_pattern(REG_PATTERN_TWO, {{5{8'h00}}, 8'h7F, 8'h80, 4'd2});
    write_pattern(REG_PATTERN_THREE, {{6{8'h00}}, 8'h7F, 4'd1});
    write_pattern(cfg_idx_t'(NUM_PATTERNS_DEF), {{6{8'h00}}, 8'hA5, 4'd1});
    write_pattern('1, {{6{8'h00}}, 8'h01, 4'd1});
    key_gaps_on  = 1'b1;
    res_stall_on = 1'b1;
    push_key(8'hFF);
    push_key(8'h00);
    push_key(8'hA5);
    push_key(8'h5A);
    push_key(8'h01);
    push_key(8'h80);
    push_key(8'h7F);
    push_key(8'h80);
    push_key(8'h7F);
    push_key(8'h7F);
    push_key(8'h01);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      key_gaps_on  = (ph % 4 != 0) && $urandom_range(0, 3) != 0;
      res_stall_on = (ph % 4 != 0) && $urandom_range(0, 3) != 0;
      if (ph == 5) key_gaps_on = 1'b0;
      random_phase(ph == 1 ? PH_ALL_ONES : (ph == 2 ? PH_SOLID : PH_RANDOM));
      if (ph == 5) hold_requests++;
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/ksm_pkg.sv
design/ksm_if.sv
design/ksm_match.sv
design/key_sequence_suffix_matcher_top.sv
bench/tb_top.sv
